[src/assert_macros.svh]
// Assertion helpers used by the RTL of the bit-set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/bfs_pkg.sv]
package bfs_pkg;

   // Fixed field widths of the command and result words.
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 12;
   localparam int POS_W   = 12;
   localparam int COUNT_W = 13;

   // Geometry of one store line.
   localparam int LINE_W = 64;
   localparam int BIT_W  = 6;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 3'd0,
      CMD_REMOVE = 3'd1,
      CMD_TEST   = 3'd2,
      CMD_FIND   = 3'd3,
      CMD_POP    = 3'd4,
      CMD_CLEAR  = 3'd5,
      CMD_FILL   = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_EXEC
   } state_type;

   // Control from the sequencer to the line store.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_nz;
      logic bulk_en;
      logic bulk_fill;
   } store_ctl_type;

endpackage

[src/bfs_ffs.sv]
module bfs_ffs #(
   parameter int WIDTH = 64,
   localparam int SEL_W = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
   input  logic [WIDTH-1:0] vec,
   output logic             any,
   output logic [SEL_W-1:0] pos
);

   // Lowest set bit: scan from the top so that the lowest hit wins.
   always_comb begin
      any = |vec;
      pos = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (vec[i]) begin
            pos = SEL_W'(i);
         end
      end
   end

endmodule

[src/bfs_store.sv]
module bfs_store #(
   parameter int MAX_ELEMENTS = 4096,
   localparam int WORD_COUNT = (MAX_ELEMENTS + 63) / 64,
   localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bfs_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]     rd_addr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [bfs_pkg::LINE_W-1:0] wr_data,
   output logic [bfs_pkg::LINE_W-1:0] rd_line,
   output logic [WORD_COUNT-1:0] nonzero
);
   import bfs_pkg::*;

   localparam int LAST_REM = MAX_ELEMENTS - (WORD_COUNT - 1) * 64;
   localparam logic [LINE_W-1:0] LAST_MASK =
      (LAST_REM >= 64) ? {LINE_W{1'b1}} : ((LINE_W'(1) << LAST_REM) - LINE_W'(1));

   logic [LINE_W-1:0]     mem [WORD_COUNT];
   logic [LINE_W-1:0]     rd_mem_ff;
   logic [WORD_COUNT-1:0] written_ff;
   logic [WORD_COUNT-1:0] nonzero_ff;
   logic                  fill_base_ff;
   logic                  rd_written_ff;
   logic                  rd_fill_ff;
   logic                  rd_last_ff;

   // Line memory with one write and one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_mem_ff <= mem[rd_addr];
      end
   end

   // Per-line flags: a line not written since the last clear or fill reads
   // as the common base pattern, so bulk commands need no pass over the lines.
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         nonzero_ff    <= '0;
         fill_base_ff  <= 1'b0;
         rd_written_ff <= 1'b0;
         rd_fill_ff    <= 1'b0;
         rd_last_ff    <= 1'b0;
      end else begin
         if (ctl.bulk_en) begin
            written_ff   <= '0;
            nonzero_ff   <= {WORD_COUNT{ctl.bulk_fill}};
            fill_base_ff <= ctl.bulk_fill;
         end else if (ctl.wr_en) begin
            written_ff[wr_addr] <= 1'b1;
            nonzero_ff[wr_addr] <= ctl.wr_nz;
         end
         if (ctl.rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
            rd_fill_ff    <= fill_base_ff;
            rd_last_ff    <= (rd_addr == ADDR_W'(WORD_COUNT - 1));
         end
      end
   end

   // Merge the stored line with the base pattern.
   always_comb begin
      if (rd_written_ff) begin
         rd_line = rd_mem_ff;
      end else if (rd_fill_ff) begin
         rd_line = rd_last_ff ? LAST_MASK : {LINE_W{1'b1}};
      end else begin
         rd_line = '0;
      end
   end

   assign nonzero = nonzero_ff;

endmodule

[src/bitset_with_find_first_core.sv]
// Channel  Direction  Handshake             Payload
// req_     in         req_valid / req_stall req_command, req_index
// rsp_     out        rsp_valid / rsp_stall rsp_is_member .. rsp_bad_index
//
// A word is taken in the idle state, reads a line of the store in the issue
// state and executes in the exec state; its result is registered as exec ends. A find
// that moves past its start line reads a second line and stays in exec for it.
// Reset clears the line flags and the count at once; there is no clearing pass.
// A word is taken while a result waits but does not execute until the result
// register is free; rsp_stall holds the result unchanged.
`include "assert_macros.svh"

module bitset_with_find_first_core #(
   parameter int MAX_ELEMENTS = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bfs_pkg::CMD_W-1:0]   req_command,
   input  logic [bfs_pkg::INDEX_W-1:0] req_index,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_is_member,
   output logic                        rsp_found,
   output logic [bfs_pkg::POS_W-1:0]   rsp_position,
   output logic [bfs_pkg::COUNT_W-1:0] rsp_member_count,
   output logic                        rsp_is_empty,
   output logic                        rsp_is_full,
   output logic                        rsp_bad_index
);
   import bfs_pkg::*;

   localparam int WORD_COUNT = (MAX_ELEMENTS + 63) / 64;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int CNT_W      = $clog2(MAX_ELEMENTS + 1);
   localparam int EXT_W      = ADDR_W + BIT_W;
   localparam int PEXT_W     = EXT_W + POS_W;
   localparam int CEXT_W     = CNT_W + COUNT_W;

   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]    line_ff, line_in;
   logic [ADDR_W-1:0]    next_line_ff, next_line_in;
   logic                 next_ok_ff, next_ok_in;
   logic                 second_ff, second_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_member_ff, rsp_member_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]     rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_full_ff, rsp_full_in;
   logic                 rsp_bad_ff, rsp_bad_in;

   store_ctl_type        ctl;
   logic [ADDR_W-1:0]    rd_addr;
   logic [LINE_W-1:0]    wr_data;
   logic [LINE_W-1:0]    rd_line;
   logic [WORD_COUNT-1:0] nonzero;

   logic [EXT_W-1:0]     line_ext;
   logic [ADDR_W-1:0]    start_line;
   logic [WORD_COUNT-1:0] above;
   logic [WORD_COUNT-1:0] sum_vec;
   logic                 sum_any;
   logic [ADDR_W-1:0]    sum_pos;

   logic                 idx_ok;
   logic                 bad;
   logic [LINE_W-1:0]    bit_sel;
   logic [LINE_W-1:0]    scan_mask;
   logic [LINE_W-1:0]    scan_line;
   logic [LINE_W-1:0]    cleared_line;
   logic                 bit_any;
   logic [BIT_W-1:0]     bit_pos;
   logic [PEXT_W-1:0]    pos_ext;
   logic [CEXT_W-1:0]    count_ext;
   logic                 out_free;
   logic                 done;

   // Decoding of the held command word.
   assign idx_ok     = (32'(idx_ff) < MAX_ELEMENTS);
   assign bad        = (cmd_ff <= CMD_FIND) && !idx_ok;
   assign line_ext   = EXT_W'(idx_ff[INDEX_W-1:BIT_W]);
   assign start_line = line_ext[ADDR_W-1:0];
   assign bit_sel    = LINE_W'(1) << idx_ff[BIT_W-1:0];

   // Summary search: lowest nonempty line, or lowest one past the start line.
   always_comb begin
      for (int i = 0; i < WORD_COUNT; i++) begin
         above[i] = (ADDR_W'(i) > start_line);
      end
      sum_vec = (cmd_ff == CMD_POP) ? nonzero : (nonzero & above);
   end

   bfs_ffs #(.WIDTH(WORD_COUNT)) u_sum_ffs (
      .vec (sum_vec),
      .any (sum_any),
      .pos (sum_pos)
   );

   // Lowest member within the line just read.
   assign scan_mask = (cmd_ff == CMD_FIND && !second_ff) ?
                      ({LINE_W{1'b1}} << idx_ff[BIT_W-1:0]) : {LINE_W{1'b1}};
   assign scan_line = rd_line & scan_mask;

   bfs_ffs #(.WIDTH(LINE_W)) u_bit_ffs (
      .vec (scan_line),
      .any (bit_any),
      .pos (bit_pos)
   );

   assign cleared_line = rd_line & ~(LINE_W'(1) << bit_pos);
   assign pos_ext      = PEXT_W'({line_ff, bit_pos});
   assign count_ext    = CEXT_W'(count_in);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   bfs_store #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .rd_addr (rd_addr),
      .wr_addr (line_ff),
      .wr_data (wr_data),
      .rd_line (rd_line),
      .nonzero (nonzero)
   );

   // Sequencer: next state, store control and result.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      line_in       = line_ff;
      next_line_in  = next_line_ff;
      next_ok_in    = next_ok_ff;
      second_in     = second_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_member_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_pos_in    = '0;
      rsp_bad_in    = 1'b0;
      ctl           = '0;
      rd_addr       = line_ff;
      wr_data       = rd_line;
      done          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               idx_in   = req_index;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (cmd_ff == CMD_POP) begin
               rd_addr    = sum_pos;
               ctl.rd_en  = sum_any;
            end else begin
               rd_addr    = start_line;
               ctl.rd_en  = (cmd_ff <= CMD_FIND) && idx_ok;
            end
            line_in      = rd_addr;
            next_line_in = sum_pos;
            next_ok_in   = sum_any;
            second_in    = 1'b0;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) begin
               done = 1'b1;
               unique case (cmd_type'(cmd_ff))
                  CMD_INSERT: begin
                     if (bad) begin
                        rsp_bad_in = 1'b1;
                     end else if ((rd_line & bit_sel) == '0) begin
                        wr_data    = rd_line | bit_sel;
                        ctl.wr_en  = 1'b1;
                        ctl.wr_nz  = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     if (bad) begin
                        rsp_bad_in = 1'b1;
                     end else if ((rd_line & bit_sel) != '0) begin
                        wr_data    = rd_line & ~bit_sel;
                        ctl.wr_en  = 1'b1;
                        ctl.wr_nz  = ((rd_line & ~bit_sel) != '0);
                        count_in   = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_TEST: begin
                     rsp_bad_in    = bad;
                     rsp_member_in = !bad && ((rd_line & bit_sel) != '0);
                  end
                  CMD_FIND: begin
                     if (bad) begin
                        rsp_bad_in = 1'b1;
                     end else if (bit_any) begin
                        rsp_found_in = 1'b1;
                        rsp_pos_in   = pos_ext[POS_W-1:0];
                     end else if (next_ok_ff && !second_ff) begin
                        // Start line has nothing left: fetch the next nonempty one.
                        done       = 1'b0;
                        rd_addr    = next_line_ff;
                        ctl.rd_en  = 1'b1;
                        line_in    = next_line_ff;
                        second_in  = 1'b1;
                     end
                  end
                  CMD_POP: begin
                     if (next_ok_ff) begin
                        rsp_found_in = 1'b1;
                        rsp_pos_in   = pos_ext[POS_W-1:0];
                        wr_data      = cleared_line;
                        ctl.wr_en    = 1'b1;
                        ctl.wr_nz    = (cleared_line != '0);
                        count_in     = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_CLEAR: begin
                     ctl.bulk_en   = 1'b1;
                     ctl.bulk_fill = 1'b0;
                     count_in      = '0;
                  end
                  CMD_FILL: begin
                     ctl.bulk_en   = 1'b1;
                     ctl.bulk_fill = 1'b1;
                     count_in      = CNT_W'(MAX_ELEMENTS);
                  end
                  default: begin
                  end
               endcase
               if (done) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_count_in = count_ext[COUNT_W-1:0];
      rsp_empty_in = (count_in == '0);
      rsp_full_in  = (count_in == CNT_W'(MAX_ELEMENTS));
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         second_ff    <= 1'b0;
         next_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         second_ff    <= second_in;
         next_ok_ff   <= next_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Held command word and the result fields, loaded as the result is made.
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      line_ff      <= line_in;
      next_line_ff <= next_line_in;
      if (state_ff == ST_EXEC && done) begin
         rsp_member_ff <= rsp_member_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_full_ff   <= rsp_full_in;
         rsp_bad_ff    <= rsp_bad_in;
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_member    = rsp_member_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_position     = rsp_pos_ff;
   assign rsp_member_count = rsp_count_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_is_full      = rsp_full_ff;
   assign rsp_bad_index    = rsp_bad_ff;

   // An accepted word always moves on to the line read.
   `BFS_ASSERT_NEXT(a_accept_issue, clock, reset, req_valid && !req_stall, state_ff == ST_ISSUE, "accepted word did not reach the issue step")
   // The member count never passes the capacity.
   `BFS_ASSERT_SAME(a_count_range, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_ELEMENTS), "member count above capacity")
   // A line the summary marks as nonempty really holds a member.
   `BFS_ASSERT_SAME(a_pop_line, clock, reset, state_ff == ST_EXEC && cmd_ff == CMD_POP && next_ok_ff, rd_line != '0, "summary and line store disagree on pop")
   // The second line of a find always yields a member.
   `BFS_ASSERT_SAME(a_find_second, clock, reset, state_ff == ST_EXEC && second_ff, bit_any, "second line of a find is empty")

endmodule
